// File: src/signed_integer_to_ascii_radix_assert.svh
`ifndef SIGNED_INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define SIGNED_INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// same-cycle implication, off during reset
`define SITOA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sitoa assertion failed");

// next-cycle implication, off during reset
`define SITOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sitoa assertion failed");

`endif

// File: src/sitoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sitoa_pkg;

  localparam int VALUE_BITS   = 64;
  localparam int BUF_DEPTH    = 64;
  localparam int ADDR_BITS    = $clog2(BUF_DEPTH);
  localparam int CNT_BITS     = $clog2(BUF_DEPTH + 1);
  localparam int DIGIT_BITS   = 4;
  localparam int RADIX_BITS   = 5;
  localparam int CHAR_BITS    = 8;
  localparam int DIV_STEPS    = 8;
  localparam int DIV_CYCLES   = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W        = DIV_CYCLES * DIV_STEPS;
  localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES + 1);

  localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 5'd16;
  localparam logic [CHAR_BITS-1:0]  CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0]  CHAR_NONE  = 8'h00;

  typedef struct packed {
    logic signed [63:0] value;
    logic [4:0]         radix;
  } request_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       invalid;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [RADIX_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_BITS-1:0] remainder;
  } div_rsp_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else begin
      c = 8'h57 + {4'h0, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/sitoa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sitoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/sitoa_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sitoa_div
  import sitoa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_W-1:0]        work;
  logic [DIGIT_BITS-1:0]   rem;
  logic [RADIX_BITS-1:0]   divisor;
  logic [DIV_CNT_BITS-1:0] cyc;
  logic                    running;
  logic                    done;

  logic [DIV_W-1:0]        work_next;
  logic [DIGIT_BITS-1:0]   rem_next;

  // restoring division, DIV_STEPS quotient bits per cycle
  always_comb begin
    logic [DIGIT_BITS:0]   t;
    logic [DIGIT_BITS-1:0] r;
    logic [DIV_W-1:0]      w;
    r = rem;
    w = work;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (t >= divisor) begin
        r    = DIGIT_BITS'(t - divisor);
        w[0] = 1'b1;
      end else begin
        r = t[DIGIT_BITS-1:0];
      end
    end
    work_next = w;
    rem_next  = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cyc     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !running) begin
        work    <= DIV_W'(req.dividend);
        rem     <= '0;
        divisor <= req.divisor;
        cyc     <= DIV_CNT_BITS'(DIV_CYCLES);
        running <= 1'b1;
      end else if (running) begin
        work <= work_next;
        rem  <= rem_next;
        cyc  <= cyc - DIV_CNT_BITS'(1);
        if (cyc == DIV_CNT_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = work[VALUE_BITS-1:0];
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// File: src/signed_integer_to_ascii_radix.sv
`timescale 1ns / 1ps
`default_nettype none
`include "signed_integer_to_ascii_radix_assert.svh"

// A bad radix or the most negative value gives its single result, registered, while staying idle.
// Otherwise each digit takes a launch, a run of the 8-bit-per-cycle divider and a store; then the sign
// (for a negative value) and the digits follow at one per cycle.
// A new request is taken the cycle after the last character is registered; the receiver
// cannot stall. Digits sit in a 64x4 RAM, written low digit first and read back in reverse.
// Synchronous active-high reset returns to idle; the digit RAM is not cleared.
module signed_integer_to_ascii_radix
  import sitoa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t request,
  output logic          strobe,
  output result_t       result
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAUNCH = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_SIGN   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]            state;
  logic [VALUE_BITS-1:0] quot;
  logic [RADIX_BITS-1:0] radix_reg;
  logic                  neg;
  logic [CNT_BITS-1:0]   cnt;
  logic [ADDR_BITS-1:0]  rptr;

  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] mag;
  logic                  is_neg;
  logic                  bad;

  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [DIGIT_BITS-1:0] ram_rdata;

  assign v      = request.value[VALUE_BITS-1:0];
  assign is_neg = v[VALUE_BITS-1];
  assign mag    = is_neg ? VALUE_BITS'(~v + VALUE_BITS'(1)) : v;
  assign bad    = (request.radix < RADIX_MIN) || (request.radix > RADIX_MAX) ||
                  (is_neg && (v[VALUE_BITS-2:0] == '0));

  assign busy = (state != S_IDLE);

  assign div_req.start    = (state == S_LAUNCH);
  assign div_req.dividend = quot;
  assign div_req.divisor  = radix_reg;

  sitoa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign ram_we    = (state == S_WAIT) && div_rsp.done;
  assign ram_raddr = (state == S_SIGN) ? ADDR_BITS'(cnt - CNT_BITS'(1))
                                       : rptr - ADDR_BITS'(1);

  // last write lands before the first read, so no forwarding is needed
  sitoa_ram #(
    .WIDTH (DIGIT_BITS),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[ADDR_BITS-1:0]),
    .wdata (div_rsp.remainder),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      cnt    <= '0;
      neg    <= 1'b0;
      quot   <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cnt <= '0;
            if (bad) begin
              result.character <= CHAR_NONE;
              result.last      <= 1'b1;
              result.invalid   <= 1'b1;
              strobe           <= 1'b1;
              neg              <= 1'b0;
              quot             <= '0;
            end else begin
              quot      <= mag;
              radix_reg <= request.radix;
              neg       <= is_neg;
              state     <= S_LAUNCH;
            end
          end
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            quot <= div_rsp.quotient;
            cnt  <= cnt + CNT_BITS'(1);
            if ((div_rsp.quotient == '0) || (cnt == CNT_BITS'(BUF_DEPTH - 1))) begin
              state <= S_SIGN;
            end else begin
              state <= S_LAUNCH;
            end
          end
        end
        S_SIGN: begin
          if (neg) begin
            result.character <= CHAR_MINUS;
            result.last      <= 1'b0;
            result.invalid   <= 1'b0;
            strobe           <= 1'b1;
          end
          rptr  <= ADDR_BITS'(cnt - CNT_BITS'(1));
          state <= S_EMIT;
        end
        S_EMIT: begin
          result.character <= digit_char(ram_rdata);
          result.last      <= (rptr == '0);
          result.invalid   <= 1'b0;
          strobe           <= 1'b1;
          rptr             <= rptr - ADDR_BITS'(1);
          if (rptr == '0) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SITOA_ASSERT_NOW(a_invalid_single, clk, rst, strobe && result.invalid, result.last && (result.character == CHAR_NONE))
  `SITOA_ASSERT_NEXT(a_valid_goes_busy, clk, rst, start && !busy && !bad, busy)
  `SITOA_ASSERT_NOW(a_rem_below_radix, clk, rst, (state == S_WAIT) && div_rsp.done, {1'b0, div_rsp.remainder} < radix_reg)
  `SITOA_ASSERT_NOW(a_cnt_in_range, clk, rst, state != S_IDLE, cnt <= CNT_BITS'(BUF_DEPTH))

endmodule

`default_nettype wire

// File: tb/tb_signed_integer_to_ascii_radix.sv
`timescale 1ns / 1ps

module tb_signed_integer_to_ascii_radix;
  import sitoa_pkg::*;

  localparam bit [127:0] DIGIT_GLYPHS = "0123456789abcdef";
  localparam logic signed [63:0] MOST_POS = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] MOST_NEG = 64'sh8000_0000_0000_0000;

  class ascii_scoreboard;
    result_t expected_chars[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // expected characters for one accepted request, most significant digit first
    function void note_request(request_t req);
      logic [63:0] magnitude;
      logic [3:0]  digits[64];
      int          n;
      bit          negative;
      negative = req.value[63];
      if (req.radix < RADIX_MIN || req.radix > RADIX_MAX ||
          (negative && req.value[62:0] == 0)) begin
        expected_chars.push_back(result_t'{character: CHAR_NONE, last: 1'b1, invalid: 1'b1});
        return;
      end
      magnitude = negative ? (~req.value + 64'd1) : req.value;
      n = 0;
      do begin
        digits[n] = 4'(magnitude % req.radix);
        magnitude = magnitude / req.radix;
        n++;
      end while (magnitude != 0 && n < 64);
      if (negative) begin
        expected_chars.push_back(result_t'{character: CHAR_MINUS, last: 1'b0, invalid: 1'b0});
      end
      for (int i = n - 1; i >= 0; i--) begin
        expected_chars.push_back(result_t'{
          character: DIGIT_GLYPHS[8*(15-digits[i]) +: 8],
          last: (i == 0), invalid: 1'b0});
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: char %h last %b invalid %b",
                   got.character, got.last, got.invalid);
        end
        return;
      end
      want = expected_chars.pop_front();
      if (got.character !== want.character || got.last !== want.last ||
          got.invalid !== want.invalid) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected char %h last %b invalid %b, got char %h last %b invalid %b",
                   want.character, want.last, want.invalid,
                   got.character, got.last, got.invalid);
        end
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     strobe;
  result_t  result;

  ascii_scoreboard scoreboard = new();

  signed_integer_to_ascii_radix DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        scoreboard.note_request(request);
      end
      if (strobe) begin
        scoreboard.check_result(result);
      end
    end
  end

  task automatic send_request(input logic signed [63:0] value, input logic [4:0] radix,
                              input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    request <= request_t'{value: value, radix: radix};
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [4:0] random_radix();
    if ($urandom_range(0, 9) == 0) begin
      return 5'($urandom_range(0, 31));
    end
    return 5'($urandom_range(RADIX_MIN, RADIX_MAX));
  endfunction

  function automatic logic signed [63:0] random_value(input logic [4:0] radix);
    logic [63:0] v;
    logic [63:0] power;
    int          k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: v = 64'($urandom_range(0, 1000));
      2: v = -64'($urandom_range(1, 1000));
      3: begin
        case ($urandom_range(0, 5))
          0: v = MOST_POS;
          1: v = MOST_NEG;
          2: v = MOST_NEG + 1;
          3: v = '0;
          4: v = '1;
          default: v = 64'd1;
        endcase
      end
      4: begin
        v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        // powers of the radix and their neighbors exercise digit-count boundaries
        power = 64'd1;
        k = $urandom_range(1, 63);
        if (radix >= 2) begin
          repeat (k) if (power <= 64'(MOST_POS) / radix) power = power * radix;
        end
        v = power + 64'($urandom_range(0, 2)) - 64'd1;
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          idle_pcts[3];
    logic [4:0]  radix;
    idle_pcts = '{0, 48, 20};
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(64'sd0, 5'd10, 0);
    send_request(64'sd1, 5'd2, 0);
    send_request(-64'sd1, 5'd16, 0);
    send_request(MOST_POS, 5'd2, 0);
    send_request(MOST_POS, 5'd16, 0);
    send_request(MOST_NEG, 5'd10, 0);
    send_request(MOST_NEG + 1, 5'd2, 0);
    send_request(MOST_NEG + 1, 5'd16, 0);
    send_request(64'sh0123_4567_89ab_cdef, 5'd16, 0);
    send_request(64'shfedc_ba98_7654_3210, 5'd16, 0);
    send_request(64'sd12345, 5'd10, 0);
    send_request(-64'sd255, 5'd16, 0);
    send_request(-64'sd7, 5'd7, 0);
    send_request(64'sd35, 5'd3, 0);
    send_request(64'sd99, 5'd0, 0);
    send_request(-64'sd1, 5'd1, 0);
    send_request(64'sd42, 5'd17, 0);
    send_request(MOST_POS, 5'd31, 0);
    send_request(MOST_NEG, 5'd0, 0);
    send_request(64'sd15, 5'd16, 0);
    send_request(64'sd16, 5'd16, 0);
    wait_drained();

    foreach (idle_pcts[p]) begin
      repeat (50) begin
        radix = random_radix();
        send_request(random_value(radix), radix, idle_pcts[p]);
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: signed_integer_to_ascii_radix.f
+incdir+src
src/sitoa_pkg.sv
src/sitoa_ram.sv
src/sitoa_div.sv
src/signed_integer_to_ascii_radix.sv
tb/tb_signed_integer_to_ascii_radix.sv
